// ===== rtl/core/qpc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the modular adder of the queen path counter
// no dependencies

package qpc_pkg;

  localparam int CountW = 30;
  localparam int CfgW = 11;
  localparam int CfgIdxW = 2;

  localparam logic [CountW-1:0] PathMod = 30'd1000000007;

  localparam logic [CfgIdxW-1:0] CfgRows = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCols = 2'd1;

  typedef struct packed {
    logic [CountW-1:0] diag;
    logic [CountW-1:0] vert;
    logic [CountW-1:0] count;
  } line_entry_t;

  function automatic logic [CountW-1:0] add_mod(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PathMod}) begin
      s = s - {1'b0, PathMod};
    end
    return s[CountW-1:0];
  endfunction

endpackage

// ===== rtl/core/qpc_line_store.sv =====
`timescale 1ns / 1ps
// line store holding count, vertical and diagonal sums of the row below
// one write port, one registered read port; uses qpc_pkg

module qpc_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  qpc_pkg::line_entry_t wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output qpc_pkg::line_entry_t rd_data_o
);
  import qpc_pkg::*;

  line_entry_t mem [DEPTH];
  line_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== rtl/core/queen_move_path_count_dp_core.sv =====
`timescale 1ns / 1ps
// top level of the queen path counter: position tracking, running sums, output register
// uses qpc_pkg and qpc_line_store
//
// cells enter on the in channel in reverse raster order (bottom row first, each
// row right to left); each accepted cell gives one transaction on the out channel
// with its path count modulo 1000000007 and a flag marking the top-left cell
// the cfg channel writes rows_in_use (index 0) or cols_in_use (index 1); any
// write restarts at the goal cell of a new grid; cfg_ready_o is always high
// cells pass the read stage, then the output register; one cell per cycle is sustained
// while not stalled, set by the line store read issued at input and the write-back
// a cell re-reading the entry written in the same cycle gets the data forwarded
// when the receiver stalls, the output register holds and the read stage holds
// one more cell, then in_ready_o drops
// reset clears the position, running sums and control; sizes reset to 1; the
// line store has no reset since each entry is written before it is read

module queen_move_path_count_dp_core #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [qpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [qpc_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          blocked_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [qpc_pkg::CountW-1:0]    path_count_o,
  output logic                          last_cell_o
);
  import qpc_pkg::*;

  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [CfgW-1:0] MaxColsCfg = (MAX_COLS > 2047) ? 11'd2047 : CfgW'(MAX_COLS);
  localparam logic [CfgW-1:0] MaxRowsCfg = (MAX_ROWS > 2047) ? 11'd2047 : CfgW'(MAX_ROWS);

  logic [CfgW-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [CountW-1:0] hsum_q, hsum_d, rcount_q, rcount_d;
  logic [CountW-1:0] sdiag_q, sdiag_d, scount_q, scount_d;

  logic s1_valid_q, s1_valid_d;
  logic s1_blk_q, s1_first_q, s1_rpos_q, s1_cpos_q, s1_lastcol_q, s1_last_q;
  logic [ColW-1:0] s1_col_q;
  logic fwd_q, fwd_d;
  line_entry_t fwd_data_q;

  logic out_valid_q, out_valid_d;
  logic [CountW-1:0] out_count_q;
  logic out_last_q;

  logic cfg_fire, in_fire, advance, s1_adv;
  logic at_lastcol, at_lastrow;
  line_entry_t rd_data, below, wr_data;
  logic [CountW-1:0] vy, hx, dz, cnt;

  function automatic logic [CfgW-1:0] clamp_size(input logic [CfgW-1:0] v,
                                                 input logic [CfgW-1:0] mx);
    logic [CfgW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (v > mx) begin
      r = mx;
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_fire = cfg_valid_i & cfg_ready_o;

  assign advance = !out_valid_q || out_ready_i;
  assign s1_adv = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire = in_valid_i && in_ready_o;

  assign at_lastcol = (17'(col_q) == (17'(cols_q) - 17'd1));
  assign at_lastrow = (17'(row_q) == (17'(rows_q) - 17'd1));

  qpc_line_store #(
    .DEPTH(MAX_COLS),
    .AW(ColW)
  ) u_line_store (
    .clk_i    (clk_i),
    .wr_en_i  (s1_adv),
    .wr_addr_i(s1_col_q),
    .wr_data_i(wr_data),
    .rd_en_i  (in_fire),
    .rd_addr_i(col_q),
    .rd_data_o(rd_data)
  );

  // cell computation in the read stage
  always_comb begin
    below = fwd_q ? fwd_data_q : rd_data;
    vy = '0;
    hx = '0;
    dz = '0;
    cnt = '0;
    if (s1_first_q) begin
      cnt = CountW'(1);
    end else if (!s1_blk_q) begin
      if (s1_rpos_q) begin
        vy = add_mod(below.vert, below.count);
      end
      if (s1_cpos_q) begin
        hx = add_mod(hsum_q, rcount_q);
      end
      if (s1_rpos_q && s1_cpos_q) begin
        dz = add_mod(sdiag_q, scount_q);
      end
      cnt = add_mod(add_mod(hx, vy), dz);
    end
    wr_data.diag = dz;
    wr_data.vert = vy;
    wr_data.count = cnt;
  end

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    col_d = col_q;
    row_d = row_q;
    hsum_d = hsum_q;
    rcount_d = rcount_q;
    sdiag_d = sdiag_q;
    scount_d = scount_q;
    if (in_fire) begin
      if (at_lastcol) begin
        col_d = '0;
        row_d = at_lastrow ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
    if (s1_adv) begin
      if (s1_lastcol_q) begin
        hsum_d = '0;
        rcount_d = '0;
        sdiag_d = '0;
        scount_d = '0;
      end else begin
        hsum_d = hx;
        rcount_d = cnt;
        sdiag_d = below.diag;
        scount_d = below.count;
      end
    end
    if (cfg_fire) begin
      unique case (cfg_index_i)
        CfgRows: rows_d = clamp_size(cfg_data_i, MaxRowsCfg);
        CfgCols: cols_d = clamp_size(cfg_data_i, MaxColsCfg);
        default: ;
      endcase
      col_d = '0;
      row_d = '0;
      hsum_d = '0;
      rcount_d = '0;
      sdiag_d = '0;
      scount_d = '0;
    end
  end

  assign s1_valid_d = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  // same entry read while the previous cell writes it back
  assign fwd_d = in_fire ? (s1_adv && (s1_col_q == col_q)) : (s1_adv ? 1'b0 : fwd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CfgW'(1);
      cols_q <= CfgW'(1);
      col_q <= '0;
      row_q <= '0;
      hsum_q <= '0;
      rcount_q <= '0;
      sdiag_q <= '0;
      scount_q <= '0;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      col_q <= col_d;
      row_q <= row_d;
      hsum_q <= hsum_d;
      rcount_q <= rcount_d;
      sdiag_q <= sdiag_d;
      scount_q <= scount_d;
      s1_valid_q <= s1_valid_d;
      out_valid_q <= out_valid_d;
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_blk_q <= blocked_i;
      s1_first_q <= (row_q == '0) && (col_q == '0);
      s1_rpos_q <= (row_q != '0);
      s1_cpos_q <= (col_q != '0);
      s1_lastcol_q <= at_lastcol;
      s1_last_q <= at_lastcol && at_lastrow;
      s1_col_q <= col_q;
      fwd_data_q <= wr_data;
    end
    if (s1_adv) begin
      out_count_q <= cnt;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign path_count_o = out_count_q;
  assign last_cell_o = out_last_q;

  a_fwd_needs_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forward flag set with empty read stage");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (17'(col_q) < 17'(cols_q)) && (17'(row_q) < 17'(rows_q)))
    else $error("position beyond grid size");

  a_wrap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && at_lastcol && at_lastrow) |=> (row_q == '0) && (col_q == '0))
    else $error("position did not wrap after top-left cell");

  a_s1_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q && $stable(s1_col_q))
    else $error("read stage lost a cell under stall");

endmodule
